/* hw/rtl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// Button settings controller package
// Shared constants, pin codes, register indexes and the result item type.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned LED_COUNT_MAX = 1023;
  localparam int unsigned LED_W         = 10;
  localparam int unsigned CFG_INDEX_W   = 4;
  localparam int unsigned CFG_DATA_W    = 16;

  // Pin codes
  localparam logic [4:0] PIN_FIRST     = 5'd2;
  localparam logic [4:0] PIN_LAST      = 5'd15;
  localparam logic [4:0] PIN_PAT_DOWN  = 5'd2;
  localparam logic [4:0] PIN_PAT_UP    = 5'd3;
  localparam logic [4:0] PIN_SPD_DOWN  = 5'd4;
  localparam logic [4:0] PIN_SPD_UP    = 5'd5;
  localparam logic [4:0] PIN_INT_DOWN  = 5'd6;
  localparam logic [4:0] PIN_INT_UP    = 5'd7;
  localparam logic [4:0] PIN_LED_DOWN  = 5'd8;
  localparam logic [4:0] PIN_LED_UP    = 5'd9;
  localparam logic [4:0] PIN_RESTORE   = 5'd10;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_COUNT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT_MS    = 4'd1;

  // Reset and restore values
  localparam logic [7:0]  PATTERN_COUNT_RST = 8'd16;
  localparam logic [15:0] LOCKOUT_MS_RST    = 16'd100;
  localparam logic [15:0] SPEED_ONE         = 16'd256;
  localparam logic [7:0]  INTENSITY_HALF    = 8'd5;

  // floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT for x below 2^22
  localparam int unsigned DIV5_SHIFT = 22;
  localparam logic [19:0] DIV5_MUL   = 20'd838861;

  typedef struct packed {
    logic             accepted;
    logic [7:0]       next_pattern;
    logic [LED_W-1:0] next_led_count;
    logic [15:0]      speed_q8;
    logic [7:0]       intensity_tenths;
  } res_t;

endpackage

/* hw/rtl/button_settings_controller.sv */
// ----------------------------------------------------------------------------
// Button settings controller
// Filters button events by pin, edge and lockout time and updates the
// pattern, LED count, speed and intensity settings for the display logic.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_stall    | pin, falling_edge, now_ms,
//           |                        | current_pattern, current_led_count
//  output   | out_valid / out_stall  | accepted, next_pattern, next_led_count,
//           |                        | speed_q8, intensity_tenths
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low: an item is evaluated in the
//  cycle it is accepted and its result is registered at that edge. The
//  settings registers update at the accept edge, so the next item in the
//  following cycle sees them. A two-entry output (result register plus skid)
//  keeps intake running while one result waits; in_stall rises only when both
//  are full. The longest path is the speed scale by 4/5 or 6/5 (one constant
//  multiply by a reciprocal of five). Reset is synchronous; cfg_ready is
//  always high.
// ----------------------------------------------------------------------------
module button_settings_controller (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [4:0]                          pin,
  input  logic                                falling_edge,
  input  logic [31:0]                         now_ms,
  input  logic [7:0]                          current_pattern,
  input  logic [bsc_pkg::LED_W-1:0]           current_led_count,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                accepted,
  output logic [7:0]                          next_pattern,
  output logic [bsc_pkg::LED_W-1:0]           next_led_count,
  output logic [15:0]                         speed_q8,
  output logic [7:0]                          intensity_tenths,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers
  logic [7:0]  pattern_count;
  logic [15:0] lockout_ms;

  // Settings state
  logic                          have_last_press;
  logic [bsc_pkg::TIME_BITS-1:0] last_press_ms;
  logic [7:0]                    pattern_reg;
  logic [bsc_pkg::LED_W-1:0]     led_count_reg;
  logic [15:0]                   speed_reg;
  logic [7:0]                    intensity_reg;

  logic [7:0]                    pattern_reg_next;
  logic [bsc_pkg::LED_W-1:0]     led_count_reg_next;
  logic [15:0]                   speed_reg_next;
  logic [7:0]                    intensity_reg_next;

  // Output register and skid entry
  bsc_pkg::res_t res_next;
  bsc_pkg::res_t out_res;
  bsc_pkg::res_t skid_res;
  logic          skid_valid;

  logic in_take;
  logic out_take;
  logic out_free;

  // Event qualification
  logic                          pin_in_range;
  logic [bsc_pkg::TIME_BITS-1:0] elapsed;
  logic                          locked_out;
  logic                          press_ok;

  // Datapath intermediates
  logic [8:0]  pattern_inc;
  logic [18:0] speed_scaled;
  logic [38:0] speed_prod;
  logic [16:0] speed_quot;
  logic [16:0] led_wide;
  logic [16:0] led_clamped;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign out_free  = !out_valid || out_take;

  // Press qualification: pin window, falling edge, lockout since last press
  assign pin_in_range = (pin >= bsc_pkg::PIN_FIRST) && (pin <= bsc_pkg::PIN_LAST);
  assign elapsed      = now_ms[bsc_pkg::TIME_BITS-1:0] - last_press_ms;
  assign locked_out   = have_last_press &&
                        (elapsed < {{(bsc_pkg::TIME_BITS-16){1'b0}}, lockout_ms});
  assign press_ok     = pin_in_range && falling_edge && !locked_out;

  // Speed scale: x4 or x6, then floor divide by five via reciprocal multiply
  assign speed_scaled = (pin == bsc_pkg::PIN_SPD_UP) ?
                        ({1'b0, speed_reg, 2'b00} + {2'b00, speed_reg, 1'b0}) :
                        {1'b0, speed_reg, 2'b00};
  assign speed_prod   = {20'd0, speed_scaled} * {19'd0, bsc_pkg::DIV5_MUL};
  assign speed_quot   = speed_prod[38:bsc_pkg::DIV5_SHIFT];

  assign pattern_inc  = {1'b0, current_pattern} + 9'd1;

  // LED step before clamping to the strip maximum
  always_comb begin
    if (pin == bsc_pkg::PIN_LED_UP) begin
      led_wide = {{(17-bsc_pkg::LED_W){1'b0}}, current_led_count} + 17'd1;
    end else if (current_led_count == '0) begin
      led_wide = '0;
    end else begin
      led_wide = {{(17-bsc_pkg::LED_W){1'b0}}, current_led_count} - 17'd1;
    end
    if (led_wide > 17'(bsc_pkg::LED_COUNT_MAX)) begin
      led_clamped = 17'(bsc_pkg::LED_COUNT_MAX);
    end else begin
      led_clamped = led_wide;
    end
  end

  // Settings update for an accepted press
  always_comb begin
    pattern_reg_next   = pattern_reg;
    led_count_reg_next = led_count_reg;
    speed_reg_next     = speed_reg;
    intensity_reg_next = intensity_reg;
    if (press_ok) begin
      // Pins 4 to 9 hand the shown pattern through
      if (pin >= bsc_pkg::PIN_SPD_DOWN && pin <= bsc_pkg::PIN_LED_UP) begin
        pattern_reg_next = current_pattern;
      end
      case (pin)
        bsc_pkg::PIN_PAT_DOWN: begin
          if (current_pattern == 8'd0) begin
            pattern_reg_next = pattern_count - 8'd1;
          end else begin
            pattern_reg_next = current_pattern - 8'd1;
          end
        end
        bsc_pkg::PIN_PAT_UP: begin
          if (pattern_inc >= {1'b0, pattern_count}) begin
            pattern_reg_next = 8'd0;
          end else begin
            pattern_reg_next = pattern_inc[7:0];
          end
        end
        bsc_pkg::PIN_SPD_DOWN: begin
          speed_reg_next = speed_quot[15:0];
        end
        bsc_pkg::PIN_SPD_UP: begin
          speed_reg_next = speed_quot[16] ? 16'hFFFF : speed_quot[15:0];
        end
        bsc_pkg::PIN_INT_DOWN: begin
          if (intensity_reg != 8'd0) begin
            intensity_reg_next = intensity_reg - 8'd1;
          end
        end
        bsc_pkg::PIN_INT_UP: begin
          if (intensity_reg != 8'hFF) begin
            intensity_reg_next = intensity_reg + 8'd1;
          end
        end
        bsc_pkg::PIN_LED_DOWN, bsc_pkg::PIN_LED_UP: begin
          led_count_reg_next = led_clamped[bsc_pkg::LED_W-1:0];
        end
        bsc_pkg::PIN_RESTORE: begin
          speed_reg_next     = bsc_pkg::SPEED_ONE;
          intensity_reg_next = bsc_pkg::INTENSITY_HALF;
          pattern_reg_next   = 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_next.accepted         = press_ok;
    res_next.next_pattern     = pattern_reg_next;
    res_next.next_led_count   = led_count_reg_next;
    res_next.speed_q8         = speed_reg_next;
    res_next.intensity_tenths = intensity_reg_next;
  end

  // Control state, configuration and settings
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count   <= bsc_pkg::PATTERN_COUNT_RST;
      lockout_ms      <= bsc_pkg::LOCKOUT_MS_RST;
      have_last_press <= 1'b0;
      last_press_ms   <= '0;
      pattern_reg     <= 8'd0;
      led_count_reg   <= '0;
      speed_reg       <= bsc_pkg::SPEED_ONE;
      intensity_reg   <= bsc_pkg::INTENSITY_HALF;
      out_valid       <= 1'b0;
      skid_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bsc_pkg::CFG_PATTERN_COUNT: pattern_count <= cfg_data[7:0];
          bsc_pkg::CFG_LOCKOUT_MS:    lockout_ms    <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (in_take) begin
        if (press_ok) begin
          have_last_press <= 1'b1;
          last_press_ms   <= now_ms[bsc_pkg::TIME_BITS-1:0];
        end
        pattern_reg   <= pattern_reg_next;
        led_count_reg <= led_count_reg_next;
        speed_reg     <= speed_reg_next;
        intensity_reg <= intensity_reg_next;
      end
      // Advance the output pair: skid drains first, else the new result
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= in_take;
        end else begin
          out_valid <= in_take;
        end
      end else if (in_take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
        if (in_take) begin
          skid_res <= res_next;
        end
      end else if (in_take) begin
        out_res <= res_next;
      end
    end else if (in_take) begin
      skid_res <= res_next;
    end
  end

  assign accepted         = out_res.accepted;
  assign next_pattern     = out_res.next_pattern;
  assign next_led_count   = out_res.next_led_count;
  assign speed_q8         = out_res.speed_q8;
  assign intensity_tenths = out_res.intensity_tenths;

endmodule

/* hw/rtl/bsc_checker.sv */
// ----------------------------------------------------------------------------
// Button settings controller checker
// Port-level properties of the controller, attached by bind.
// ----------------------------------------------------------------------------
module bsc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      accepted,
  input logic [7:0]                next_pattern,
  input logic [bsc_pkg::LED_W-1:0] next_led_count,
  input logic [15:0]               speed_q8,
  input logic [7:0]                intensity_tenths
);

  // Reset empties the output pair and opens intake
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("output pair not empty after reset");

  // Intake stalls only while a result is held on the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("intake stalled with no result pending");

  // Hold a stalled result
  a_out_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(accepted) && $stable(next_pattern) &&
      $stable(next_led_count) && $stable(speed_q8) && $stable(intensity_tenths)))
    else $error("stalled result changed");

endmodule

bind button_settings_controller bsc_checker u_bsc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .accepted         (accepted),
  .next_pattern     (next_pattern),
  .next_led_count   (next_led_count),
  .speed_q8         (speed_q8),
  .intensity_tenths (intensity_tenths)
);
